>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest palette color search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;
  localparam logic [DIST_W-1:0] MAX_DISTANCE = 18'd195075;

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } req_item_t;

  typedef struct packed {
    logic [7:0]        best_index;
    logic [DIST_W-1:0] best_distance;
    logic              exact_match;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic entry_wr;
    logic capture_query;
    logic scan_rd;
    logic cnt_inc;
    logic cnt_clear;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> rtl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer: palette clear after reset, item intake, scan and result hand-off.
// ----------------------------------------------------------------------------
module nps_ctrl import nps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_func,
  output logic         req_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid && req_func == FUNC_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.scan_done) begin
          state_next = status.out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.cnt_clear = status.cnt_last;
      end
      ST_IDLE: begin
        req_ready         = 1'b1;
        cmd.entry_wr      = req_valid && req_func == FUNC_WRITE;
        cmd.capture_query = req_valid && req_func == FUNC_QUERY;
      end
      ST_SCAN: begin
        cmd.scan_rd   = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.cnt_clear = status.cnt_last;
      end
      ST_DRAIN: begin
        cmd.load_out = status.scan_done && status.out_free;
      end
      ST_HOLD: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/nps_datapath.sv
// ----------------------------------------------------------------------------
// nps_datapath
// Palette memory, address counter, distance pipeline, best-match tracking
// and the result register.
// ----------------------------------------------------------------------------
module nps_datapath import nps_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  req_item_t    req,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output rsp_item_t    rsp
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  logic [3*COLOR_W-1:0] palette [PALETTE_ENTRIES];

  logic [IDX_W-1:0]     cnt;
  logic [31:0]          entry_ext;
  logic                 entry_in_range;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [3*COLOR_W-1:0] mem_wdata;
  logic [3*COLOR_W-1:0] rdata;

  logic [COLOR_W-1:0] q_red;
  logic [COLOR_W-1:0] q_green;
  logic [COLOR_W-1:0] q_blue;

  logic             v1;
  logic             last1;
  logic             first1;
  logic [IDX_W-1:0] idx1;

  logic             v2;
  logic             last2;
  logic             first2;
  logic [IDX_W-1:0] idx2;
  logic [SQ_W-1:0]  sq_red;
  logic [SQ_W-1:0]  sq_green;
  logic [SQ_W-1:0]  sq_blue;

  logic [COLOR_W-1:0] d_red;
  logic [COLOR_W-1:0] d_green;
  logic [COLOR_W-1:0] d_blue;
  logic [DIST_W-1:0]  dist_sum;
  logic               take;

  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic [31:0]       best_ext;
  logic              scan_done;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign entry_ext      = 32'(req.entry_index);
  assign entry_in_range = entry_ext < 32'(PALETTE_ENTRIES);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.entry_wr && entry_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = entry_ext[IDX_W-1:0];
      mem_wdata = {req.red, req.green, req.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= palette[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_query) begin
      q_red   <= req.red;
      q_green <= req.green;
      q_blue  <= req.blue;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
    end
    idx1   <= cnt;
    last1  <= cnt == LAST_IDX;
    first1 <= cnt == '0;
  end

  assign d_red   = abs_diff(q_red,   rdata[3*COLOR_W-1:2*COLOR_W]);
  assign d_green = abs_diff(q_green, rdata[2*COLOR_W-1:COLOR_W]);
  assign d_blue  = abs_diff(q_blue,  rdata[COLOR_W-1:0]);

  // square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    idx2     <= idx1;
    last2    <= last1;
    first2   <= first1;
    sq_red   <= SQ_W'(d_red) * SQ_W'(d_red);
    sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue  <= SQ_W'(d_blue) * SQ_W'(d_blue);
  end

  // sum and compare stage
  assign dist_sum = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  assign take     = v2 && (first2 || dist_sum < best_dist);

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= idx2;
      best_dist <= dist_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
    end else begin
      scan_done <= v2 && last2;
    end
  end

  assign best_ext = 32'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.best_index    <= best_ext[7:0];
      rsp.best_distance <= best_dist;
      rsp.exact_match   <= best_dist == '0;
    end
  end

  assign status.cnt_last  = cnt == LAST_IDX;
  assign status.scan_done = scan_done;
  assign status.out_free  = !rsp_valid || rsp_ready;

endmodule

>>> rtl/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette store with a nearest-color search over squared RGB distance.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_item_t  (write entry or query)
//   rsp      out  rsp_valid/rsp_ready   rsp_item_t  (one per query)
//
// A query scans the palette one entry per cycle through the single read port
// of the palette memory, followed by a three-stage distance pipeline.
// After reset the palette is cleared entry by entry; req_ready stays low
// meanwhile. A finished result waits in the output register while the next
// item is taken; a query done with that register still full waits.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top import nps_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nps_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> rtl/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for the nearest palette color search block.
// ----------------------------------------------------------------------------
module nps_checker import nps_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item taken during palette clear");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.func == FUNC_QUERY) |=> !req_ready)
    else $error("item taken during a scan");

  a_exact_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.exact_match == (rsp.best_distance == '0)))
    else $error("exact flag disagrees with distance");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.best_distance <= MAX_DISTANCE)
    else $error("distance out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind nearest_palette_color_search_top nps_checker u_nps_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
